// ===== hw/rtl/ccse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_pkg
// shared types and constants of the contour cell segment extractor
// ----------------------------------------------------------------------------
package ccse_pkg;

  localparam int GridMaxDefault = 1024;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_STEP_X   = 3'd2,
    REG_STEP_Y   = 3'd3,
    REG_VCAP     = 3'd4,
    REG_COLOUR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]         cell_col;
    logic [9:0]         cell_row;
    logic signed [15:0] height_00;
    logic signed [15:0] height_10;
    logic signed [15:0] height_01;
    logic signed [15:0] height_11;
    logic signed [15:0] level;
    logic               last_cell;
  } cell_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [31:0]        colour;
    logic [19:0]        vertices_written;
  } seg_t;

  // one queued edge job: two interpolations of a crossed edge pair
  typedef struct packed {
    logic               emit;
    logic               last_cell;
    logic signed [16:0] num_a;   // level - ha for first edge
    logic signed [16:0] den_a;   // hb - ha
    logic signed [17:0] xa_a;
    logic signed [17:0] ya_a;
    logic signed [16:0] dx_a;
    logic signed [16:0] dy_a;
    logic signed [16:0] num_b;
    logic signed [16:0] den_b;
    logic signed [17:0] xa_b;
    logic signed [17:0] ya_b;
    logic signed [16:0] dx_b;
    logic signed [16:0] dy_b;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) r = 16'sd32767;
    else if (v < -36'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/ccse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_if
// valid/ready channel interfaces for items and configuration writes
// ----------------------------------------------------------------------------
interface ccse_cell_if;
  ccse_pkg::cell_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccse_seg_if;
  ccse_pkg::seg_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccse_cfg_if;
  logic [ccse_pkg::CfgIdxW-1:0]  index;
  logic [ccse_pkg::CfgDataW-1:0] wdata;
  logic valid;
  logic ready;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/contour_cell_segment_extractor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_cell_segment_extractor_unit
// marching-squares cell to line segment, one segment per cell at most
// ----------------------------------------------------------------------------
// path: front coordinate and job registers, job queue, back divide and
// output states; a cell with no segment ends when the back takes its job
// divider: serial, forms four 35-bit quotients in turn while the front and
// queue take cells; empty cells pass at 1 a cycle unless the back is busy
// reset: synchronous active-low, registers to defaults, vertex count zero
module contour_cell_segment_extractor_unit #(
  parameter int GRID_MAX = ccse_pkg::GridMaxDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  ccse_cell_if.sink      in_ch,
  ccse_seg_if.source     out_ch,
  ccse_cfg_if.sink       cfg_ch
);
  import ccse_pkg::*;

  logic signed [15:0] origin_x_r, origin_y_r;
  logic [14:0]        step_x_r, step_y_r;
  logic [19:0]        vcap_r;
  logic [31:0]        colour_r;
  logic               fq_valid, fq_ready, qb_valid, qb_ready;
  job_t               fq_job, qb_job;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      step_x_r   <= 15'd4096;
      step_y_r   <= 15'd4096;
      vcap_r     <= '1;
      colour_r   <= '1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ORIGIN_X: origin_x_r <= cfg_ch.wdata[15:0];
        REG_ORIGIN_Y: origin_y_r <= cfg_ch.wdata[15:0];
        REG_STEP_X:   step_x_r   <= cfg_ch.wdata[14:0];
        REG_STEP_Y:   step_y_r   <= cfg_ch.wdata[14:0];
        REG_VCAP:     vcap_r     <= cfg_ch.wdata[19:0];
        REG_COLOUR:   colour_r   <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  ccse_front #(.GRID_MAX(GRID_MAX)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cell(in_ch.data),
    .origin_x(origin_x_r), .origin_y(origin_y_r),
    .step_x(step_x_r), .step_y(step_y_r),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  ccse_queue #(.DEPTH(4)) u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
  );

  ccse_back u_back (
    .clk, .rst_n,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .vertex_capacity(vcap_r), .segment_colour(colour_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_seg(out_ch.data)
  );

endmodule

// ===== hw/rtl/ccse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_front
// accepts cells, finds corner coordinates and the first two crossed edges
// ----------------------------------------------------------------------------
module ccse_front #(
  parameter int GRID_MAX = ccse_pkg::GridMaxDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ccse_pkg::cell_t           in_cell,
  input  logic signed [15:0]        origin_x,
  input  logic signed [15:0]        origin_y,
  input  logic [14:0]               step_x,
  input  logic [14:0]               step_y,
  output logic                      job_valid,
  input  logic                      job_ready,
  output ccse_pkg::job_t            job
);
  import ccse_pkg::*;

  // stage one: coordinates, registered after the multiply
  logic               s1_valid_r, s1_valid_nxt;
  cell_t              s1_cell_r;
  logic signed [26:0] x0_r, y0_r;
  logic               job_valid_r, job_valid_nxt;
  job_t               job_r;
  logic               s1_go;

  assign job_valid = job_valid_r;
  assign job       = job_r;
  assign s1_go     = !job_valid_r || job_ready;
  assign in_ready  = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) s1_valid_nxt = in_valid;
    job_valid_nxt = job_valid_r;
    if (s1_go) job_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cell_r <= in_cell;
      x0_r <= 27'(origin_x) + $signed({1'b0, 26'(in_cell.cell_col * step_x)});
      y0_r <= 27'(origin_y) + $signed({1'b0, 26'(in_cell.cell_row * step_y)});
    end
  end

  // stage two: edge tests and pick of the first two crossings
  logic signed [16:0] ha [4];
  logic signed [16:0] hb [4];
  logic signed [17:0] ex [4];
  logic signed [17:0] ey [4];
  logic signed [16:0] edx [4];
  logic signed [16:0] edy [4];
  logic [3:0]         crs;
  logic signed [16:0] lv;
  logic signed [27:0] x1, y1;
  logic signed [16:0] sx, sy;
  logic               in_grid;
  job_t               job_nxt;
  logic [1:0]         ia, ib;
  logic [2:0]         ncr;

  always_comb begin
    lv = 17'(s1_cell_r.level);
    sx = $signed({2'b00, step_x});
    sy = $signed({2'b00, step_y});
    x1 = 28'(x0_r) + 28'(sx);
    y1 = 28'(y0_r) + 28'(sy);
    ha[0] = 17'(s1_cell_r.height_00); hb[0] = 17'(s1_cell_r.height_10);
    ha[1] = 17'(s1_cell_r.height_10); hb[1] = 17'(s1_cell_r.height_11);
    ha[2] = 17'(s1_cell_r.height_11); hb[2] = 17'(s1_cell_r.height_01);
    ha[3] = 17'(s1_cell_r.height_01); hb[3] = 17'(s1_cell_r.height_00);
    // start coordinates clamped: origin plus cell index times step can lie far
    // outside 18 bits, so each corner coordinate saturates at 18 bits
    ex[0] = x0_r > 27'sd131071 ? 18'sd131071 : (x0_r < -27'sd131072 ? -18'sd131072 : 18'(x0_r));
    ey[0] = y0_r > 27'sd131071 ? 18'sd131071 : (y0_r < -27'sd131072 ? -18'sd131072 : 18'(y0_r));
    ex[1] = x1 > 28'sd131071 ? 18'sd131071 : (x1 < -28'sd131072 ? -18'sd131072 : 18'(x1));
    ey[1] = ey[0];
    ex[2] = ex[1];
    ey[2] = y1 > 28'sd131071 ? 18'sd131071 : (y1 < -28'sd131072 ? -18'sd131072 : 18'(y1));
    ex[3] = ex[0];
    ey[3] = ey[2];
    edx[0] = sx;  edy[0] = '0;
    edx[1] = '0;  edy[1] = sy;
    edx[2] = -sx; edy[2] = '0;
    edx[3] = '0;  edy[3] = -sy;
    for (int i = 0; i < 4; i++) begin
      crs[i] = (ha[i] < lv && hb[i] > lv) || (ha[i] > lv && hb[i] < lv);
    end
    ncr = 3'(crs[0]) + 3'(crs[1]) + 3'(crs[2]) + 3'(crs[3]);
    ia = crs[0] ? 2'd0 : (crs[1] ? 2'd1 : 2'd2);
    priority if (crs[0] && crs[1]) ib = 2'd1;
    else if ((crs[0] || crs[1]) && crs[2]) ib = 2'd2;
    else ib = 2'd3;
    in_grid = (32'(s1_cell_r.cell_col) < GRID_MAX) && (32'(s1_cell_r.cell_row) < GRID_MAX);
    job_nxt.emit = in_grid && (ncr >= 3'd2);
    job_nxt.last_cell = s1_cell_r.last_cell;
    job_nxt.num_a = lv - ha[ia];
    job_nxt.den_a = hb[ia] - ha[ia];
    job_nxt.xa_a = ex[ia];
    job_nxt.ya_a = ey[ia];
    job_nxt.dx_a = edx[ia];
    job_nxt.dy_a = edy[ia];
    job_nxt.num_b = lv - ha[ib];
    job_nxt.den_b = hb[ib] - ha[ib];
    job_nxt.xa_b = ex[ib];
    job_nxt.ya_b = ey[ib];
    job_nxt.dx_b = edx[ib];
    job_nxt.dy_b = edy[ib];
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid_r) job_r <= job_nxt;
  end

endmodule

// ===== hw/rtl/ccse_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_queue
// short fifo of edge jobs between front and back
// ----------------------------------------------------------------------------
module ccse_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  ccse_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output ccse_pkg::job_t rd_data
);
  import ccse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t            mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            wr_go, rd_go;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr_go    = wr_valid && wr_ready;
  assign rd_go    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (wr_go) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (rd_go) rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(wr_go) - (AW+1)'(rd_go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== hw/rtl/ccse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_back
// interpolates the two crossings with a serial divider, counts vertices
// ----------------------------------------------------------------------------
module ccse_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  ccse_pkg::job_t job,
  input  logic [19:0]    vertex_capacity,
  input  logic [31:0]    segment_colour,
  output logic           out_valid,
  input  logic           out_ready,
  output ccse_pkg::seg_t out_seg
);
  import ccse_pkg::*;

  localparam int NW = 35;   // magnitude of 2*num*delta + den
  localparam int DW = 18;   // 2*den

  bk_state_t          st_r, st_nxt;
  job_t               job_r;
  logic [1:0]         sel_r, sel_nxt;      // which of four quotients
  logic [5:0]         bit_r, bit_nxt;
  logic [NW-1:0]      quo_r;
  logic [DW:0]        rem_r;
  logic [DW-1:0]      dv_r;
  logic               neg_r;
  logic signed [35:0] res_r [4];
  logic [19:0]        vcnt_r, vcnt_nxt;
  seg_t               seg_r;
  logic               ov_r, ov_nxt;
  logic               job_go, fit;

  logic signed [16:0] cn, cd, cdl;
  logic signed [17:0] cb;
  logic signed [33:0] prod;
  logic [NW-1:0]      nmag;
  logic [DW-1:0]      dmag;
  logic               cneg;
  logic [DW:0]        rtry;
  logic [DW:0]        rsh;
  logic [NW-1:0]      quo_step;

  assign out_valid = ov_r;
  assign out_seg   = seg_r;
  assign job_ready = st_r == BK_IDLE && !ov_r;
  assign job_go    = job_valid && job_ready;
  assign fit       = 21'(vcnt_r) + 21'd2 <= 21'(vertex_capacity);

  // operand set for quotient sel
  always_comb begin
    unique case (sel_r)
      2'd0: begin cn = job_r.num_a; cdl = job_r.dx_a; cd = job_r.den_a; cb = job_r.xa_a; end
      2'd1: begin cn = job_r.num_a; cdl = job_r.dy_a; cd = job_r.den_a; cb = job_r.ya_a; end
      2'd2: begin cn = job_r.num_b; cdl = job_r.dx_b; cd = job_r.den_b; cb = job_r.xa_b; end
      default: begin
        cn = job_r.num_b; cdl = job_r.dy_b; cd = job_r.den_b; cb = job_r.ya_b;
      end
    endcase
    prod = 34'(cn) * 34'(cdl);
    cneg = (prod < 0) != (cd < 0);
    nmag = NW'(2 * (prod < 0 ? -35'(prod) : 35'(prod))) + NW'(cd < 0 ? -18'(cd) : 18'(cd));
    dmag = DW'(2 * (cd < 0 ? -18'(cd) : 18'(cd)));
    rsh  = {rem_r[DW-1:0], quo_r[NW-1]};
    rtry = rsh - {1'b0, dv_r};
    quo_step = {quo_r[NW-2:0], !rtry[DW]};
  end

  always_comb begin
    st_nxt   = st_r;
    sel_nxt  = sel_r;
    bit_nxt  = bit_r;
    vcnt_nxt = vcnt_r;
    ov_nxt   = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        sel_nxt = '0;
        bit_nxt = '0;
        if (job_valid && !ov_r) begin
          if (job.emit && fit) begin
            st_nxt = BK_DIV;
          end else if (job.last_cell) begin
            vcnt_nxt = '0;
          end
        end
      end
      BK_DIV: begin
        if (bit_r == 6'(NW)) begin
          bit_nxt = '0;
          if (sel_r == 2'd3) st_nxt = BK_OUT;
          else sel_nxt = sel_r + 2'd1;
        end else begin
          bit_nxt = bit_r + 6'd1;
        end
      end
      BK_OUT: begin
        st_nxt = BK_IDLE;
        ov_nxt = 1'b1;
        vcnt_nxt = job_r.last_cell ? '0 : vcnt_r + 20'd2;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      sel_r  <= '0;
      bit_r  <= '0;
      vcnt_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      sel_r  <= sel_nxt;
      bit_r  <= bit_nxt;
      vcnt_r <= vcnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // restoring divider, one quotient bit a cycle; load on bit zero
  always_ff @(posedge clk) begin
    if (job_go) job_r <= job;
    if (st_r == BK_DIV && bit_r == 6'(NW)) begin
      res_r[sel_r] <= 36'(cb) + (neg_r ? -36'($signed({1'b0, quo_step}))
                                       : 36'($signed({1'b0, quo_step})));
    end
    if (st_r == BK_DIV && bit_r == 6'd0) begin
      quo_r <= nmag;
      rem_r <= '0;
      dv_r  <= dmag;
      neg_r <= cneg;
    end else if (st_r == BK_DIV) begin
      if (!rtry[DW]) begin
        rem_r <= rtry;
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= rsh;
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
    end
    if (st_r == BK_OUT) begin
      seg_r.start_x <= sat16(res_r[0]);
      seg_r.start_y <= sat16(res_r[1]);
      seg_r.end_x   <= sat16(res_r[2]);
      seg_r.end_y   <= sat16(res_r[3]);
      seg_r.colour  <= segment_colour;
      seg_r.vertices_written <= vcnt_r + 20'd2;
    end
  end

endmodule

// ===== hw/rtl/ccse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_checker
// port-level checks of the extractor, bound to the top level
// ----------------------------------------------------------------------------
module ccse_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input ccse_pkg::seg_t out_data
);
  import ccse_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_vcount_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.vertices_written[0] == 1'b0)
    else $error("odd vertex count");

  a_vcount_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.vertices_written >= 20'd2)
    else $error("vertex count below two");

endmodule

bind contour_cell_segment_extractor_unit ccse_checker u_ccse_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== test/ccse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccse_tb_checker
// watches the cell, segment and register channels of the contour extractor,
// works out the expected segment of every accepted cell from its own copy of
// the registers and vertex count, and compares each segment field by field
// ----------------------------------------------------------------------------
module ccse_tb_checker (
  input  logic  clk,
  input  logic  rst_n,
  ccse_cell_if  in_ch,
  ccse_seg_if   out_ch,
  ccse_cfg_if   cfg_ch,
  output int    fail_count,
  output int    segs_waiting,
  output int    cells_seen,
  output int    segs_seen
);
  import ccse_pkg::*;

  localparam int GridMax = GridMaxDefault;

  longint    org_x, org_y;
  longint    stp_x, stp_y;
  logic [19:0] vcap;
  logic [31:0] colour_reg;
  logic [19:0] vcount;
  seg_t      segs_due[$];

  function automatic longint round_div(longint num, longint den);
    longint q;
    logic   neg;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    neg = num < 0;
    if (neg) num = -num;
    q = (2 * num + den) / (2 * den);
    return neg ? -q : q;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  task automatic predict_segment(input cell_t c);
    longint x0, x1, y0, y1, lv;
    longint ha[4], hb[4], xa[4], ya[4], xb[4], yb[4];
    longint pts[4];
    int     np;
    seg_t   s;
    np = 0;
    if (c.cell_col < GridMax && c.cell_row < GridMax) begin
      x0 = org_x + longint'(c.cell_col) * stp_x;
      x1 = x0 + stp_x;
      y0 = org_y + longint'(c.cell_row) * stp_y;
      y1 = y0 + stp_y;
      lv = c.level;
      // bottom, right, top, left
      ha[0] = c.height_00; hb[0] = c.height_10;
      xa[0] = x0; ya[0] = y0; xb[0] = x1; yb[0] = y0;
      ha[1] = c.height_10; hb[1] = c.height_11;
      xa[1] = x1; ya[1] = y0; xb[1] = x1; yb[1] = y1;
      ha[2] = c.height_11; hb[2] = c.height_01;
      xa[2] = x1; ya[2] = y1; xb[2] = x0; yb[2] = y1;
      ha[3] = c.height_01; hb[3] = c.height_00;
      xa[3] = x0; ya[3] = y1; xb[3] = x0; yb[3] = y0;
      for (int e = 0; e < 4; e++) begin
        if (np < 4 && ((ha[e] < lv && hb[e] > lv) || (ha[e] > lv && hb[e] < lv))) begin
          pts[np]     = xa[e] + round_div((lv - ha[e]) * (xb[e] - xa[e]), hb[e] - ha[e]);
          pts[np + 1] = ya[e] + round_div((lv - ha[e]) * (yb[e] - ya[e]), hb[e] - ha[e]);
          np += 2;
        end
      end
      if (np >= 4 && longint'(vcount) + 2 <= longint'(vcap)) begin
        vcount = vcount + 20'd2;
        s.start_x = clip16(pts[0]);
        s.start_y = clip16(pts[1]);
        s.end_x = clip16(pts[2]);
        s.end_y = clip16(pts[3]);
        s.colour = colour_reg;
        s.vertices_written = vcount;
        segs_due.insert(segs_due.size(), s);
      end
    end
    if (c.last_cell) vcount = '0;
  endtask

  task automatic report(input string what, input longint exp_v, input longint got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    seg_t e, g;
    if (!rst_n) begin
      org_x = 0;
      org_y = 0;
      stp_x = 4096;
      stp_y = 4096;
      vcap = 20'hfffff;
      colour_reg = 32'hffffffff;
      vcount = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_ORIGIN_X: org_x = longint'($signed(cfg_ch.wdata[15:0]));
          REG_ORIGIN_Y: org_y = longint'($signed(cfg_ch.wdata[15:0]));
          REG_STEP_X:   stp_x = cfg_ch.wdata[14:0];
          REG_STEP_Y:   stp_y = cfg_ch.wdata[14:0];
          REG_VCAP:     vcap = cfg_ch.wdata[19:0];
          REG_COLOUR:   colour_reg = cfg_ch.wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        cells_seen++;
        predict_segment(in_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        segs_seen++;
        g = out_ch.data;
        if (segs_due.size() == 0) begin
          report("unexpected segment, vertices_written", -1, g.vertices_written);
        end else begin
          e = segs_due.pop_front();
          if (g.start_x !== e.start_x) report("start_x", e.start_x, g.start_x);
          if (g.start_y !== e.start_y) report("start_y", e.start_y, g.start_y);
          if (g.end_x !== e.end_x) report("end_x", e.end_x, g.end_x);
          if (g.end_y !== e.end_y) report("end_y", e.end_y, g.end_y);
          if (g.colour !== e.colour) report("colour", e.colour, g.colour);
          if (g.vertices_written !== e.vertices_written)
            report("vertices_written", e.vertices_written, g.vertices_written);
        end
      end
    end
    segs_waiting = segs_due.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// contour extractor regression: directed corner cases then bursts of random
// cells under several register settings, with random receiver stalls
// ----------------------------------------------------------------------------
module tb;
  import ccse_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 400;
  localparam logic [CfgIdxW-1:0] RegSpare = CfgIdxW'(REG_COLOUR + 1);

  logic clk;
  logic rst_n;
  int   fail_count, segs_waiting, cells_seen, segs_seen;
  int   idle_cycles;
  bit   hold_req;
  bit   hold_done;

  ccse_cell_if in_if ();
  ccse_seg_if  out_if ();
  ccse_cfg_if  cfg_if ();

  contour_cell_segment_extractor_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  ccse_tb_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .cfg_ch       (cfg_if),
    .fail_count   (fail_count),
    .segs_waiting (segs_waiting),
    .cells_seen   (cells_seen),
    .segs_seen    (segs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern, with a single long hold-off in the second random phase
  initial begin
    int mode;
    out_if.ready = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (2500) @(negedge clk);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= ($urandom_range(0, 9) == 0);
        default: out_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] near(longint base, int spread);
    longint v;
    v = base + $signed($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int    k;
    int    spread;
    c.cell_col = 10'($urandom);
    c.cell_row = 10'($urandom);
    c.level = 16'($urandom);
    c.last_cell = ($urandom_range(0, 15) == 0);
    k = $urandom_range(0, 99);
    spread = 1 << $urandom_range(1, 14);
    if (k < 35) begin
      c.height_00 = 16'($urandom);
      c.height_10 = 16'($urandom);
      c.height_01 = 16'($urandom);
      c.height_11 = 16'($urandom);
    end else if (k < 85) begin
      c.height_00 = near(c.level, spread);
      c.height_10 = near(c.level, spread);
      c.height_01 = near(c.level, spread);
      c.height_11 = near(c.level, spread);
    end else if (k < 93) begin
      // all corners on one side
      c.level = near(0, 1000);
      c.height_00 = 16'(c.level + 16'sd1 + $urandom_range(0, 500));
      c.height_10 = 16'(c.level + 16'sd1 + $urandom_range(0, 500));
      c.height_01 = 16'(c.level + 16'sd1 + $urandom_range(0, 500));
      c.height_11 = 16'(c.level + 16'sd1 + $urandom_range(0, 500));
    end else begin
      // some corners sit exactly on the level
      c.height_00 = $urandom_range(0, 1) ? c.level : near(c.level, spread);
      c.height_10 = $urandom_range(0, 1) ? c.level : near(c.level, spread);
      c.height_01 = $urandom_range(0, 1) ? c.level : near(c.level, spread);
      c.height_11 = $urandom_range(0, 1) ? c.level : near(c.level, spread);
    end
    return c;
  endfunction

  function automatic cell_t mk(int col, int row, int h00, int h10, int h01, int h11,
                               int lv, bit last);
    cell_t c;
    c.cell_col = 10'(col);
    c.cell_row = 10'(row);
    c.height_00 = 16'(h00);
    c.height_10 = 16'(h10);
    c.height_01 = 16'(h01);
    c.height_11 = 16'(h11);
    c.level = 16'(lv);
    c.last_cell = last;
    return c;
  endfunction

  task automatic send_cell(input cell_t c);
    @(negedge clk);
    in_if.data <= c;
    in_if.valid <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    pause_sender(1);
    while (segs_waiting != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_regs(input int ox, input int oy, input int sx, input int sy,
                          input int cap, input logic [31:0] col);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_VCAP, cap);
    write_reg(REG_COLOUR, col);
  endtask

  task automatic random_burst(input int n);
    int left;
    left = n;
    while (left > 0) begin
      for (int b = $urandom_range(1, 30); b > 0 && left > 0; b--) begin
        send_cell(random_cell());
        left--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // directed cells under reset register values
    send_cell(mk(0, 0, -100, 100, -100, 100, 0, 0));
    send_cell(mk(3, 5, 100, 100, -100, -100, 0, 0));
    send_cell(mk(1, 1, -100, 100, 100, -100, 0, 0));
    send_cell(mk(2, 2, 0, 100, -100, 100, 0, 0));
    send_cell(mk(4, 4, 5, 5, 5, 5, 5, 0));
    send_cell(mk(5, 5, -300, 700, 700, 700, 0, 0));
    send_cell(mk(1023, 1023, -32768, 32767, -32768, 32767, 0, 0));
    send_cell(mk(1023, 0, 32767, -32768, 32767, 32767, -32768, 0));
    send_cell(mk(0, 1023, 32767, -32768, -32768, -32768, 32767, 1));
    send_cell(mk(7, 9, -1, 1, 1, 1, 0, 0));
    send_cell(mk(8, 8, -32768, -32768, -32768, 32767, 32766, 1));
    send_cell(mk(9, 9, 1, 2, 3, 4, 10, 0));
    drain();

    // saturation and negative origins
    set_regs(-32768, 32767, 32767, 32767, 1048575, 32'h0);
    send_cell(mk(1023, 1023, -100, 100, -100, 100, 0, 0));
    send_cell(mk(0, 0, -100, 100, 100, 100, 0, 1));
    drain();
    write_reg(RegSpare, 32'h1234);
    write_reg(CfgIdxW'(RegSpare + 1), 32'hffff);
    send_cell(mk(0, 0, 100, -100, 100, 100, 0, 0));
    drain();

    // full buffer: capacity zero, then room for two segments
    set_regs(0, 0, 0, 0, 0, 32'hdeadbeef);
    send_cell(mk(1, 1, -100, 100, -100, 100, 0, 0));
    send_cell(mk(2, 2, -100, 100, -100, 100, 0, 1));
    drain();
    write_reg(REG_VCAP, 5);
    for (int i = 0; i < 4; i++) send_cell(mk(i, i, -100, 100, -100, 100, 0, i == 3));
    send_cell(mk(6, 6, -100, 100, -100, 100, 0, 0));
    drain();

    // random phases under several settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(0, 0, 4096, 4096, 1048575, 32'hffffffff);
        1: set_regs(-32768, -32768, 32767, 32767, 1048575, $urandom);
        2: set_regs(32767, 32767, 0, 0, 1048575, 32'h0);
        3: set_regs(0, 0, 1, 1, 0, $urandom);
        4: set_regs($urandom, $urandom, $urandom_range(0, 64), $urandom_range(0, 64),
                    $urandom_range(4, 40), $urandom);
        default: set_regs($urandom, $urandom, $urandom_range(0, 32767),
                          $urandom_range(0, 32767), $urandom_range(0, 1048575), $urandom);
      endcase
      if (ph == 1) hold_req = 1'b1;
      random_burst(68);
      drain();
    end

    $display("cells accepted %0d, segments checked %0d over directed and random phases",
             cells_seen, segs_seen);
    $display("covered saddles, level-touching corners, saturation, full buffer, stalls");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ccse_pkg.sv
hw/rtl/ccse_if.sv
hw/rtl/ccse_front.sv
hw/rtl/ccse_queue.sv
hw/rtl/ccse_back.sv
hw/rtl/contour_cell_segment_extractor_unit.sv
hw/rtl/ccse_checker.sv
test/ccse_checker.sv
test/tb.sv
